@@ rtl/core/arp_pkg.sv @@
// Shared constants, mode codes and the CORDIC arctangent table for the
// rotation-about-pivot block. Depends on nothing.
package arp_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // CORDIC datapath: x and y in Q2.30, z in 2^32 units per turn.
  localparam int TW = 32;
  localparam int ZW = 33;
  localparam int ATAN_COUNT = 24;
  localparam logic signed [TW-1:0] INV_GAIN = TW'(652032874);

  // Rotation axis codes.
  localparam logic [1:0] MODE_X    = 2'd0;
  localparam logic [1:0] MODE_Y    = 2'd1;
  localparam logic [1:0] MODE_Z    = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  // Arctangent of 2^-i in 2^32 units per turn.
  function automatic logic signed [ZW-1:0] atan_units(input int unsigned idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:  val = ZW'(536870912);
      1:  val = ZW'(316933406);
      2:  val = ZW'(167458907);
      3:  val = ZW'(85004756);
      4:  val = ZW'(42667331);
      5:  val = ZW'(21354465);
      6:  val = ZW'(10679838);
      7:  val = ZW'(5340245);
      8:  val = ZW'(2670163);
      9:  val = ZW'(1335087);
      10: val = ZW'(667544);
      11: val = ZW'(333772);
      12: val = ZW'(166886);
      13: val = ZW'(83443);
      14: val = ZW'(41722);
      15: val = ZW'(20861);
      16: val = ZW'(10430);
      17: val = ZW'(5215);
      18: val = ZW'(2608);
      19: val = ZW'(1304);
      20: val = ZW'(652);
      21: val = ZW'(326);
      22: val = ZW'(163);
      23: val = ZW'(81);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/core/arp_combine.sv @@
// Three-stage multiply, sum and round for one rotated coordinate, with the
// final saturation left combinational. Depends on arp_pkg.
module arp_combine #(
  parameter int COORD_WIDTH = arp_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic [2:0]                    en_i,
  input  logic signed [COORD_WIDTH:0]   da_i,
  input  logic signed [arp_pkg::TW-1:0] k1_i,
  input  logic signed [COORD_WIDTH:0]   db_i,
  input  logic signed [arp_pkg::TW-1:0] k2_i,
  input  logic signed [COORD_WIDTH-1:0] piv_i,
  output logic signed [COORD_WIDTH-1:0] res_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int TW  = arp_pkg::TW;
  localparam int DW  = CW + 1;
  localparam int LO  = DW / 2;
  localparam int HI  = DW - LO;
  localparam int PW  = DW + TW;
  localparam int SW  = PW + 1;
  localparam int QW  = SW - 30;
  localparam int RW  = QW + 1;
  localparam logic signed [SW-1:0] RND = SW'(1) <<< 29;
  localparam logic signed [RW-1:0] SAT_MAX = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_MIN = {{(RW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic signed [HI-1:0]     da_hi, db_hi;
  logic signed [LO:0]       da_lo, db_lo;
  logic signed [HI+TW-1:0]  ph1_q, ph2_q;
  logic signed [LO+TW:0]    pl1_q, pl2_q;
  logic signed [PW-1:0]     prod1_q, prod2_q;
  logic signed [SW-1:0]     sum_q;
  logic signed [QW-1:0]     quot;
  logic signed [RW-1:0]     res;

  // The operand is split so each multiplier stays near 32 bits wide.
  assign da_hi = $signed(da_i[DW-1:LO]);
  assign db_hi = $signed(db_i[DW-1:LO]);
  assign da_lo = $signed({1'b0, da_i[LO-1:0]});
  assign db_lo = $signed({1'b0, db_i[LO-1:0]});

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ph1_q <= da_hi * k1_i;
      pl1_q <= da_lo * k1_i;
      ph2_q <= db_hi * k2_i;
      pl2_q <= db_lo * k2_i;
    end
    if (en_i[1]) begin
      prod1_q <= (PW'(ph1_q) <<< LO) + PW'(pl1_q);
      prod2_q <= (PW'(ph2_q) <<< LO) + PW'(pl2_q);
    end
    if (en_i[2]) begin
      sum_q <= SW'(prod1_q) + SW'(prod2_q) + RND;
    end
  end

  assign quot = sum_q[SW-1:30];
  assign res  = RW'(quot) + RW'(piv_i);

  always_comb begin
    if (res > SAT_MAX) begin
      res_o = SAT_MAX[CW-1:0];
    end else if (res < SAT_MIN) begin
      res_o = SAT_MIN[CW-1:0];
    end else begin
      res_o = res[CW-1:0];
    end
  end

endmodule

@@ rtl/core/axis_rotation_about_pivot.sv @@
// Top level of the point rotation about a pivot around one coordinate axis.
// Depends on arp_pkg and arp_combine.
//
//   Channel  Handshake                  Payload
//   -------  -------------------------  ------------------------------------
//   in       in_valid_i / in_ready_o    mode, vec_x/y/z, pivot_x/y/z, angle
//   out      out_valid_o / out_ready_i  out_x, out_y, out_z
//
// One item enters per cycle while in_ready_o is high. Each item passes
// through the entry stage, the unrolled CORDIC with one micro-rotation per
// stage, the quadrant stage, three multiply/sum stages and the output
// register.
// Reset clears only the valid bits; the payload registers are left as is.
// Every stage carries its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles fill up while a result waits at the output.
//
// The entry stage selects the two off-axis coordinates and forms their
// offsets from the pivot. For the unused mode the offsets are forced to zero
// and the pivot is replaced by the point itself, so the rotated result equals
// the point and no bypass path is needed.
module axis_rotation_about_pivot #(
  parameter int COORD_WIDTH   = arp_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = arp_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = arp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic signed [COORD_WIDTH-1:0] vec_x_i,
  input  logic signed [COORD_WIDTH-1:0] vec_y_i,
  input  logic signed [COORD_WIDTH-1:0] vec_z_i,
  input  logic signed [COORD_WIDTH-1:0] pivot_x_i,
  input  logic signed [COORD_WIDTH-1:0] pivot_y_i,
  input  logic signed [COORD_WIDTH-1:0] pivot_z_i,
  input  logic [ANGLE_WIDTH-1:0]        angle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic signed [COORD_WIDTH-1:0] out_z_o
);

  localparam int CW = COORD_WIDTH;
  localparam int AW = ANGLE_WIDTH;
  localparam int N  = CORDIC_STAGES;
  localparam int TW = arp_pkg::TW;
  localparam int ZW = arp_pkg::ZW;
  // Stages: entry, N CORDIC, quadrant, three in the combiners, output.
  localparam int L  = N + 6;
  localparam int ZSHIFT = 32 - AW;

  typedef struct packed {
    logic [1:0]           mode;
    logic [1:0]           quad;
    logic signed [CW-1:0] axis;
    logic signed [CW-1:0] pa;
    logic signed [CW-1:0] pb;
    logic signed [CW:0]   da;
    logic signed [CW:0]   db;
  } side_t;

  logic [L-1:0] valid_q;
  logic [L-1:0] valid_in;
  logic [L:0]   en;

  side_t                side_q [N+5];
  side_t                side_d;
  logic signed [TW-1:0] cx_q [N+1];
  logic signed [TW-1:0] cy_q [N+1];
  logic signed [ZW-1:0] cz_q [N+1];
  logic [ZW-1:0]        z0;

  logic signed [TW-1:0] c_q, s_q, ns_q;
  logic signed [TW-1:0] c_d, s_d;
  logic signed [CW-1:0] res_a, res_b;
  logic signed [CW-1:0] out_x_q, out_y_q, out_z_q;

  // Stage load enables: a stage moves when it is empty or its successor moves.
  always_comb begin
    en[L] = out_ready_i;
    for (int k = L - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign valid_in   = {valid_q[L-2:0], in_valid_i};
  assign in_ready_o = en[0];
  assign out_valid_o = valid_q[L-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < L; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_in[k];
        end
      end
    end
  end

  // Entry: axis selection and offsets from the pivot.
  always_comb begin
    side_d.mode = mode_i;
    side_d.quad = angle_i[AW-1:AW-2];
    case (mode_i)
      arp_pkg::MODE_X: begin
        side_d.axis = vec_x_i;
        side_d.pa   = pivot_y_i;
        side_d.pb   = pivot_z_i;
        side_d.da   = (CW+1)'(vec_y_i) - (CW+1)'(pivot_y_i);
        side_d.db   = (CW+1)'(vec_z_i) - (CW+1)'(pivot_z_i);
      end
      arp_pkg::MODE_Y: begin
        side_d.axis = vec_y_i;
        side_d.pa   = pivot_x_i;
        side_d.pb   = pivot_z_i;
        side_d.da   = (CW+1)'(vec_x_i) - (CW+1)'(pivot_x_i);
        side_d.db   = (CW+1)'(vec_z_i) - (CW+1)'(pivot_z_i);
      end
      arp_pkg::MODE_Z: begin
        side_d.axis = vec_z_i;
        side_d.pa   = pivot_x_i;
        side_d.pb   = pivot_y_i;
        side_d.da   = (CW+1)'(vec_x_i) - (CW+1)'(pivot_x_i);
        side_d.db   = (CW+1)'(vec_y_i) - (CW+1)'(pivot_y_i);
      end
      default: begin
        // Unused mode: zero offsets about the point itself pass it through.
        side_d.axis = vec_z_i;
        side_d.pa   = vec_x_i;
        side_d.pb   = vec_y_i;
        side_d.da   = '0;
        side_d.db   = '0;
      end
    endcase
  end

  // The angle below the quadrant bits, scaled to 2^32 units per turn.
  assign z0 = {{(ZW-AW+2){1'b0}}, angle_i[AW-3:0]} << ZSHIFT;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= side_d;
      cx_q[0]   <= arp_pkg::INV_GAIN;
      cy_q[0]   <= '0;
      cz_q[0]   <= $signed(z0);
    end
  end

  // Unrolled CORDIC, one micro-rotation per register stage.
  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [TW-1:0] dx, dy;
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en[1+i]) begin
        side_q[i+1] <= side_q[i];
        if (!cz_q[i][ZW-1]) begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          cz_q[i+1] <= cz_q[i] - arp_pkg::atan_units(i);
        end else begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          cz_q[i+1] <= cz_q[i] + arp_pkg::atan_units(i);
        end
      end
    end
  end

  // Quadrant fold-out of cosine and sine.
  always_comb begin
    case (side_q[N].quad)
      2'd0: begin
        c_d = cx_q[N];
        s_d = cy_q[N];
      end
      2'd1: begin
        c_d = -cy_q[N];
        s_d = cx_q[N];
      end
      2'd2: begin
        c_d = -cx_q[N];
        s_d = -cy_q[N];
      end
      default: begin
        c_d = cy_q[N];
        s_d = -cx_q[N];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[N+1]) begin
      side_q[N+1] <= side_q[N];
      c_q  <= c_d;
      s_q  <= s_d;
      ns_q <= -s_d;
    end
  end

  // Side data keeps pace with the combiners so the pivot lines up at the end.
  for (genvar j = 0; j < 3; j++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en[N+2+j]) begin
        side_q[N+2+j] <= side_q[N+1+j];
      end
    end
  end

  // a' = pa + da*cos - db*sin,  b' = pb + da*sin + db*cos
  arp_combine #(
    .COORD_WIDTH(CW)
  ) u_comb_a (
    .clk_i (clk_i),
    .en_i  (en[N+4:N+2]),
    .da_i  (side_q[N+1].da),
    .k1_i  (c_q),
    .db_i  (side_q[N+1].db),
    .k2_i  (ns_q),
    .piv_i (side_q[N+4].pa),
    .res_o (res_a)
  );

  arp_combine #(
    .COORD_WIDTH(CW)
  ) u_comb_b (
    .clk_i (clk_i),
    .en_i  (en[N+4:N+2]),
    .da_i  (side_q[N+1].da),
    .k1_i  (s_q),
    .db_i  (side_q[N+1].db),
    .k2_i  (c_q),
    .piv_i (side_q[N+4].pb),
    .res_o (res_b)
  );

  // Output register: put the axis coordinate back in its place.
  always_ff @(posedge clk_i) begin
    if (en[N+5]) begin
      case (side_q[N+4].mode)
        arp_pkg::MODE_X: begin
          out_x_q <= side_q[N+4].axis;
          out_y_q <= res_a;
          out_z_q <= res_b;
        end
        arp_pkg::MODE_Y: begin
          out_x_q <= res_a;
          out_y_q <= side_q[N+4].axis;
          out_z_q <= res_b;
        end
        default: begin
          out_x_q <= res_a;
          out_y_q <= res_b;
          out_z_q <= side_q[N+4].axis;
        end
      endcase
    end
  end

  assign out_x_o = out_x_q;
  assign out_y_o = out_y_q;
  assign out_z_o = out_z_q;

endmodule
